// ===== sv/mppc_history_decompressor_unit_assert.svh =====
// Assertion macros used by the decompressor unit.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef MPPC_HISTORY_DECOMPRESSOR_UNIT_ASSERT_SVH
`define MPPC_HISTORY_DECOMPRESSOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPPC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPPC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== sv/mppc_pkg.sv =====
package mppc_pkg;

	// History store geometry; the depth is a power of two.
	localparam int HISTORY_BYTES = 65536;
	localparam int HIST_AW = $clog2(HISTORY_BYTES);

	// Usable history for the two codings.
	localparam logic [16:0] LIM_LARGE = 17'(HISTORY_BYTES);
	localparam logic [16:0] LIM_SMALL = (HISTORY_BYTES < 8192) ?
		17'(HISTORY_BYTES) : 17'd8192;

	// Operations.
	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_DONE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_PASS = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EOF    = 2'd1;
	localparam logic [1:0] ST_BADREF = 2'd2;
	localparam logic [1:0] ST_BADLEN = 2'd3;

	// Token phases.
	localparam logic [3:0] PH_PREFIX = 4'd0;
	localparam logic [3:0] PH_LIT7   = 4'd1;
	localparam logic [3:0] PH_LIT8   = 4'd2;
	localparam logic [3:0] PH_OFF6   = 4'd3;
	localparam logic [3:0] PH_OFF8   = 4'd4;
	localparam logic [3:0] PH_OFF11  = 4'd5;
	localparam logic [3:0] PH_OFF13  = 4'd6;
	localparam logic [3:0] PH_OFF16  = 4'd7;
	localparam logic [3:0] PH_ONES   = 4'd8;
	localparam logic [3:0] PH_LEN    = 4'd9;

	// Offset bases and length run limits.
	localparam logic [16:0] OFF8_BASE  = 17'd64;
	localparam logic [16:0] OFF11_BASE = 17'd320;
	localparam logic [16:0] OFF16_BASE = 17'd2368;
	localparam logic [3:0] ONES_MAX_LARGE = 4'd14;
	localparam logic [3:0] ONES_MAX_SMALL = 4'd11;

	typedef struct packed {
		logic        operation;
		logic        byte_valid;
		logic [7:0]  data_byte;
		logic        first_of_packet;
		logic        last_of_packet;
		logic        reset_history;
		logic        move_to_front;
		logic        packet_compressed;
		logic        large_history;
		logic [15:0] read_address;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [1:0]  status;
		logic [16:0] start_index;
		logic [16:0] packet_length;
		logic [7:0]  out_byte;
		logic        out_last;
	} out_item_t;

endpackage

// ===== sv/mppc_in_if.sv =====
interface mppc_in_if import mppc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== sv/mppc_out_if.sv =====
interface mppc_out_if import mppc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== sv/mppc_ram.sv =====
// Simple dual-port RAM with a registered read.
module mppc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wdat,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         dout
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wdat;
		end
		dout <= mem[ra];
	end
endmodule

// ===== sv/mppc_history_decompressor_unit.sv =====
// MPPC decompressor with up to 64K of history. Items are taken one at a time.
// A history read passes a read-wait state and a pass-through byte the item state,
// then both the emit state and the output register. A compressed byte passes the
// item state, a decode step per prefix, literal, offset, unary length bit and
// length field, a check state per copy token, a read and a write state per copied
// byte, because the single history RAM reads the source and then writes the
// destination, and a finish state; the last byte of a packet adds the emit state.
// Results sit in an output register, so the next item is taken while a result
// waits; a second result waits in the unit until that register frees up.
`include "mppc_history_decompressor_unit_assert.svh"
module mppc_history_decompressor_unit import mppc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	mppc_in_if.sink    in_ch,
	mppc_out_if.source out_ch
);
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_ITEM      = 3'd1;
	localparam logic [2:0] S_DECODE    = 3'd2;
	localparam logic [2:0] S_COPY_CHK  = 3'd3;
	localparam logic [2:0] S_COPY_RD   = 3'd4;
	localparam logic [2:0] S_COPY_WR   = 3'd5;
	localparam logic [2:0] S_FINISH    = 3'd6;
	localparam logic [2:0] S_EMIT      = 3'd7;
	localparam logic [2:0] S_READ_WAIT = 3'd2;

	logic [2:0]         state_q;
	logic               rwait_q;
	in_item_t           item_q;
	logic [16:0]        wi_q, ps_q, vs_q, off_q, len_q;
	logic [23:0]        buf_q;
	logic [4:0]         cnt_q;
	logic [3:0]         phase_q, ones_q;
	logic [1:0]         mode_q, err_q;
	logic [HIST_AW-1:0] src_q;
	out_item_t          res_q, out_item_q;
	logic               out_valid_q;

	logic               mem_we;
	logic [HIST_AW-1:0] mem_wa, mem_ra;
	logic [7:0]         mem_wdat, mem_dout;

	mppc_ram #(.WIDTH(8), .DEPTH(HISTORY_BYTES)) u_hist (
		.clk (clk),
		.we  (mem_we),
		.wa  (mem_wa),
		.wdat(mem_wdat),
		.ra  (mem_ra),
		.dout(mem_dout)
	);

	// Bit extraction from the top of the bit buffer.
	logic        hist64, enough, in_xfer;
	logic [23:0] aligned;
	logic [4:0]  need_w, pfx_take;
	logic [15:0] field;
	logic [4:0]  pfx5;
	logic [3:0]  pfx_next, ones_thr;
	logic [16:0] lim;
	logic [7:0]  lit;

	assign in_xfer = in_ch.valid && in_ch.ready;
	assign hist64 = mode_q[1];
	assign lim = hist64 ? LIM_LARGE : LIM_SMALL;
	assign ones_thr = hist64 ? ONES_MAX_LARGE : ONES_MAX_SMALL;
	assign aligned = buf_q << (5'd24 - cnt_q);
	assign field = aligned[23:8] >> (5'd16 - need_w);
	assign enough = cnt_q >= need_w;
	assign pfx5 = hist64 ? aligned[23:19] : {aligned[23:20], 1'b0};
	assign lit = {phase_q == PH_LIT8, field[6:0]};

	always_comb begin
		case (phase_q)
			PH_PREFIX: need_w = hist64 ? 5'd5 : 5'd4;
			PH_LIT7:   need_w = 5'd7;
			PH_LIT8:   need_w = 5'd7;
			PH_OFF6:   need_w = 5'd6;
			PH_OFF8:   need_w = 5'd8;
			PH_OFF11:  need_w = 5'd11;
			PH_OFF13:  need_w = 5'd13;
			PH_OFF16:  need_w = 5'd16;
			PH_LEN:    need_w = {1'b0, ones_q} + 5'd1;
			default:   need_w = 5'd1;
		endcase
	end

	// Prefix decode: how many bits the prefix takes and what follows it.
	always_comb begin
		if (!pfx5[4]) begin
			pfx_take = 5'd1;
			pfx_next = PH_LIT7;
		end else if (!pfx5[3]) begin
			pfx_take = 5'd2;
			pfx_next = PH_LIT8;
		end else if (!pfx5[2]) begin
			pfx_take = 5'd3;
			pfx_next = hist64 ? PH_OFF16 : PH_OFF13;
		end else if (hist64 && !pfx5[1]) begin
			pfx_take = 5'd4;
			pfx_next = PH_OFF11;
		end else begin
			pfx_take = hist64 ? 5'd5 : 5'd4;
			pfx_next = (hist64 ? pfx5[0] : pfx5[1]) ? PH_OFF6 : PH_OFF8;
		end
	end

	// Offset base for the current offset phase.
	logic [16:0] off_base;
	always_comb begin
		case (phase_q)
			PH_OFF8:  off_base = OFF8_BASE;
			PH_OFF11: off_base = OFF11_BASE;
			PH_OFF13: off_base = OFF11_BASE;
			PH_OFF16: off_base = OFF16_BASE;
			default:  off_base = '0;
		endcase
	end

	// Copy setup: source address and range checks.
	logic [17:0] src_calc, copy_end;
	logic        copy_bad;
	assign src_calc = (wi_q >= off_q) ? ({1'b0, wi_q} - {1'b0, off_q}) :
		({1'b0, wi_q} + {1'b0, lim} - {1'b0, off_q});
	assign copy_end = {1'b0, wi_q} + {1'b0, len_q};
	assign copy_bad = ((wi_q < off_q) && ((off_q - wi_q) > lim)) ||
		(copy_end > {1'b0, lim});

	// Packet end status.
	logic [1:0] fin_status;
	always_comb begin
		fin_status = err_q;
		if (err_q == ST_OK && phase_q != PH_PREFIX && phase_q != PH_LIT7) begin
			fin_status = ST_EOF;
		end
	end

	// History RAM access.
	logic lit_write;
	assign lit_write = (state_q == S_DECODE) && !rwait_q && (err_q == ST_OK) && enough &&
		(phase_q == PH_LIT7 || phase_q == PH_LIT8) && (wi_q < lim);
	assign mem_we = lit_write || (state_q == S_COPY_WR);
	assign mem_wa = wi_q[HIST_AW-1:0];
	assign mem_wdat = lit_write ? lit : mem_dout;
	assign mem_ra = (state_q == S_IDLE) ? in_ch.item.read_address[HIST_AW-1:0] : src_q;

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.item = out_item_q;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && (!out_valid_q || out_ch.ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && (!out_valid_q || out_ch.ready)) begin
			out_item_q <= res_q;
		end else if (rwait_q) begin
			out_item_q <= out_item_q;
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rwait_q <= 1'b0;
			wi_q <= '0;
			ps_q <= '0;
			vs_q <= '0;
			buf_q <= '0;
			cnt_q <= '0;
			phase_q <= PH_PREFIX;
			ones_q <= '0;
			off_q <= '0;
			mode_q <= '0;
			err_q <= ST_OK;
			len_q <= '0;
			src_q <= '0;
			item_q <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						item_q <= in_ch.item;
						if (in_ch.item.operation == OP_READ) begin
							rwait_q <= 1'b1;
							state_q <= S_READ_WAIT;
						end else begin
							state_q <= S_ITEM;
							if (in_ch.item.first_of_packet) begin
								if (in_ch.item.reset_history || in_ch.item.move_to_front) begin
									wi_q <= '0;
									ps_q <= '0;
								end else begin
									wi_q <= ps_q;
								end
								if (in_ch.item.reset_history) begin
									vs_q <= '0;
								end
								mode_q <= {in_ch.item.large_history,
									in_ch.item.packet_compressed};
								buf_q <= '0;
								cnt_q <= '0;
								phase_q <= PH_PREFIX;
								ones_q <= '0;
								off_q <= '0;
								err_q <= ST_OK;
							end
						end
					end
				end
				S_ITEM: begin
					if (!mode_q[0]) begin
						if (item_q.byte_valid) begin
							res_q <= '{KIND_PASS, ST_OK, 17'd0, 17'd0,
								item_q.data_byte, item_q.last_of_packet};
							state_q <= S_EMIT;
						end else if (item_q.last_of_packet) begin
							res_q <= '{KIND_DONE, ST_OK, wi_q, 17'd0, 8'd0, 1'b0};
							state_q <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (item_q.byte_valid && err_q == ST_OK) begin
						buf_q <= {buf_q[15:0], item_q.data_byte};
						cnt_q <= cnt_q + 5'd8;
						state_q <= S_DECODE;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_DECODE: begin
					if (rwait_q) begin
						// A history read result, parked on the registered RAM output.
						rwait_q <= 1'b0;
						res_q <= '{KIND_READ, ST_OK, 17'd0, 17'd0, mem_dout, 1'b0};
						state_q <= S_EMIT;
					end else if (err_q != ST_OK || !enough) begin
						state_q <= S_FINISH;
					end else begin
						case (phase_q)
							PH_PREFIX: begin
								cnt_q <= cnt_q - pfx_take;
								phase_q <= pfx_next;
							end
							PH_LIT7, PH_LIT8: begin
								cnt_q <= cnt_q - 5'd7;
								phase_q <= PH_PREFIX;
								if (wi_q >= lim) begin
									err_q <= ST_BADREF;
								end else begin
									wi_q <= wi_q + 17'd1;
								end
							end
							PH_OFF6, PH_OFF8, PH_OFF11, PH_OFF13, PH_OFF16: begin
								cnt_q <= cnt_q - need_w;
								off_q <= {1'b0, field} + off_base;
								ones_q <= '0;
								phase_q <= PH_ONES;
							end
							PH_ONES: begin
								cnt_q <= cnt_q - 5'd1;
								if (aligned[23]) begin
									if (ones_q != 4'd15) begin
										ones_q <= ones_q + 4'd1;
									end
								end else if (ones_q > ones_thr) begin
									err_q <= ST_BADLEN;
									state_q <= S_FINISH;
								end else if (ones_q == 4'd0) begin
									phase_q <= PH_PREFIX;
									len_q <= 17'd3;
									state_q <= S_COPY_CHK;
								end else begin
									phase_q <= PH_LEN;
								end
							end
							PH_LEN: begin
								cnt_q <= cnt_q - need_w;
								phase_q <= PH_PREFIX;
								len_q <= (17'd1 << need_w) | {1'b0, field};
								state_q <= S_COPY_CHK;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_COPY_CHK: begin
					if (copy_bad) begin
						err_q <= ST_BADREF;
						state_q <= S_FINISH;
					end else begin
						src_q <= src_calc[HIST_AW-1:0];
						state_q <= S_COPY_RD;
					end
				end
				S_COPY_RD: begin
					state_q <= S_COPY_WR;
				end
				S_COPY_WR: begin
					wi_q <= wi_q + 17'd1;
					src_q <= src_q + 1'b1;
					len_q <= len_q - 17'd1;
					state_q <= (len_q == 17'd1) ? S_DECODE : S_COPY_RD;
				end
				S_FINISH: begin
					if (!item_q.last_of_packet) begin
						state_q <= S_IDLE;
					end else begin
						res_q <= '{KIND_DONE, fin_status, ps_q,
							(fin_status == ST_OK) ? wi_q - ps_q : 17'd0, 8'd0, 1'b0};
						if (fin_status == ST_OK) begin
							ps_q <= wi_q;
							if (wi_q > vs_q) begin
								vs_q <= wi_q;
							end
						end else begin
							wi_q <= ps_q;
						end
						buf_q <= '0;
						cnt_q <= '0;
						phase_q <= PH_PREFIX;
						ones_q <= '0;
						off_q <= '0;
						err_q <= ST_OK;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A copy write always follows the read of its source byte.
	`MPPC_ASSERT_NEXT(a_copy_order, state_q == S_COPY_RD, state_q == S_COPY_WR, "copy write without source read")
	// Copy writes stay inside the usable history.
	`MPPC_ASSERT_NOW(a_copy_in_range, state_q == S_COPY_WR, wi_q < lim, "copy write past history limit")
	// The bit buffer never holds more bits than it has room for.
	`MPPC_ASSERT_NOW(a_bits_fit, state_q == S_DECODE && !rwait_q, cnt_q <= 5'd24, "bit count overflow")
	// A transfer always leaves the idle state.
	`MPPC_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_q != S_IDLE, "transfer not taken up")
endmodule

// ===== test/mppc_history_decompressor_unit_tb.sv =====
`timescale 1ns / 100ps

module mppc_history_decompressor_unit_tb;
	import mppc_pkg::*;

	localparam int IDLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1950;

	logic clk;
	logic arst_n;

	mppc_in_if in_ch();
	mppc_out_if out_ch();

	mppc_history_decompressor_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Predicted decompressor state.
	logic [7:0] hist_mem [HISTORY_BYTES];
	int unsigned wr_idx, pkt_start, valid_size, bit_buf, bit_cnt;
	int unsigned phase, ones_cnt, match_off, pkt_mode, pkt_err;

	out_item_t expected_results[$];
	int mismatch_count;
	int items_sent;
	int burst_left;
	bit steady_sender;
	int hold_left;
	bit hold_request;
	bit stream_bits[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Decoder restart at packet boundaries.
	function automatic void clear_decoder();
		bit_buf = 0;
		bit_cnt = 0;
		phase = PH_PREFIX;
		ones_cnt = 0;
		match_off = 0;
		pkt_err = 0;
	endfunction

	function automatic int unsigned hist_limit();
		return pkt_mode[1] ? int'(LIM_LARGE) : int'(LIM_SMALL);
	endfunction

	function automatic int unsigned grab_bits(int unsigned w);
		int unsigned v;
		v = (bit_buf >> (bit_cnt - w)) & ((1 << w) - 1);
		bit_cnt -= w;
		return v;
	endfunction

	function automatic void store_literal(int unsigned c);
		if (wr_idx >= hist_limit()) begin
			pkt_err = ST_BADREF;
			return;
		end
		hist_mem[wr_idx % HISTORY_BYTES] = c[7:0];
		wr_idx++;
	endfunction

	function automatic void copy_match(int unsigned len);
		int unsigned lim, src;
		lim = hist_limit();
		if (wr_idx >= match_off) begin
			src = wr_idx - match_off;
		end else begin
			if (match_off - wr_idx > lim) begin
				pkt_err = ST_BADREF;
				return;
			end
			src = wr_idx + lim - match_off;
		end
		if (wr_idx + len > lim) begin
			pkt_err = ST_BADREF;
			return;
		end
		while (len > 0) begin
			hist_mem[wr_idx % HISTORY_BYTES] = hist_mem[src % HISTORY_BYTES];
			wr_idx++;
			src++;
			len--;
		end
	endfunction

	// Consumes buffered bits until a token runs out of input or an error stops it.
	function automatic void decode_tokens();
		bit hist64;
		int unsigned w, base, v, lb, sel;
		hist64 = pkt_mode[1];
		while (pkt_err == 0) begin
			w = 0;
			base = 0;
			case (phase)
				PH_LIT7, PH_LIT8: begin
					if (bit_cnt < 7) return;
					v = grab_bits(7);
					store_literal(phase == PH_LIT8 ? (v | 8'h80) : v);
					phase = PH_PREFIX;
					continue;
				end
				PH_OFF6: begin w = 6; base = 0; end
				PH_OFF8: begin w = 8; base = OFF8_BASE; end
				PH_OFF11: begin w = 11; base = OFF11_BASE; end
				PH_OFF13: begin w = 13; base = OFF11_BASE; end
				PH_OFF16: begin w = 16; base = OFF16_BASE; end
				PH_ONES: begin
					if (bit_cnt < 1) return;
					if (grab_bits(1) != 0) begin
						if (ones_cnt < 15) ones_cnt++;
						continue;
					end
					if (ones_cnt > (hist64 ? ONES_MAX_LARGE : ONES_MAX_SMALL)) begin
						pkt_err = ST_BADLEN;
						return;
					end
					phase = PH_PREFIX;
					if (ones_cnt == 0) copy_match(3);
					else phase = PH_LEN;
					continue;
				end
				PH_LEN: begin
					w = ones_cnt + 1;
					if (bit_cnt < w) return;
					v = grab_bits(w);
					phase = PH_PREFIX;
					copy_match((1 << w) | v);
					continue;
				end
				default: begin
					lb = hist64 ? 5 : 4;
					if (bit_cnt < lb) return;
					v = (bit_buf >> (bit_cnt - lb)) & ((1 << lb) - 1);
					if (!hist64) v = v << 1;
					if (!v[4]) begin
						void'(grab_bits(1));
						phase = PH_LIT7;
					end else if (!v[3]) begin
						void'(grab_bits(2));
						phase = PH_LIT8;
					end else if (!v[2]) begin
						void'(grab_bits(3));
						phase = hist64 ? PH_OFF16 : PH_OFF13;
					end else if (hist64 && !v[1]) begin
						void'(grab_bits(4));
						phase = PH_OFF11;
					end else begin
						sel = hist64 ? v[0] : v[1];
						void'(grab_bits(lb));
						phase = sel ? PH_OFF6 : PH_OFF8;
					end
					continue;
				end
			endcase
			if (bit_cnt < w) return;
			match_off = grab_bits(w) + base;
			ones_cnt = 0;
			phase = PH_ONES;
		end
	endfunction

	// Works out the result, if any, that one accepted item causes.
	function automatic bit decompress_step(in_item_t it, output out_item_t r);
		int unsigned st, len;
		r = '0;
		if (it.operation == OP_READ) begin
			r.result_kind = KIND_READ;
			r.out_byte = hist_mem[it.read_address];
			return 1'b1;
		end
		if (it.first_of_packet) begin
			wr_idx = pkt_start;
			if (it.reset_history) begin
				wr_idx = 0;
				valid_size = 0;
			end
			if (it.move_to_front) wr_idx = 0;
			pkt_start = wr_idx;
			pkt_mode = {it.large_history, it.packet_compressed};
			clear_decoder();
		end
		if (!pkt_mode[0]) begin
			if (it.byte_valid) begin
				r.result_kind = KIND_PASS;
				r.out_byte = it.data_byte;
				r.out_last = it.last_of_packet;
				return 1'b1;
			end
			if (it.last_of_packet) begin
				r.result_kind = KIND_DONE;
				r.start_index = wr_idx[16:0];
				return 1'b1;
			end
			return 1'b0;
		end
		if (it.byte_valid && pkt_err == 0) begin
			bit_buf = ((bit_buf << 8) | it.data_byte) & 24'hFFFFFF;
			bit_cnt += 8;
			decode_tokens();
		end
		if (!it.last_of_packet) return 1'b0;
		st = pkt_err;
		if (st == 0 && phase != PH_PREFIX && phase != PH_LIT7) st = ST_EOF;
		if (st == 0) begin
			len = wr_idx - pkt_start;
			if (wr_idx > valid_size) valid_size = wr_idx;
		end else begin
			wr_idx = pkt_start;
			len = 0;
		end
		r.result_kind = KIND_DONE;
		r.status = st[1:0];
		r.start_index = pkt_start[16:0];
		r.packet_length = len[16:0];
		pkt_start = wr_idx;
		clear_decoder();
		return 1'b1;
	endfunction

	// Bit stream building, MSB first.
	function automatic void put_bits(int unsigned v, int n);
		for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
	endfunction

	function automatic void put_literal(logic [7:0] c);
		if (!c[7]) put_bits({1'b0, c[6:0]}, 8);
		else put_bits({2'b10, c[6:0]}, 9);
	endfunction

	function automatic void put_length(int unsigned len);
		int k;
		if (len <= 3) begin
			put_bits(0, 1);
			return;
		end
		k = $clog2(len + 1) - 2;
		put_bits((1 << k) - 1, k);
		put_bits(0, 1);
		put_bits(len, k + 1);
	endfunction

	function automatic void put_copy(int unsigned off, int unsigned len, bit hist64);
		if (hist64) begin
			if (off < 64) put_bits({5'b11111, off[5:0]}, 11);
			else if (off < 320) put_bits({5'b11110, 8'(off - 64)}, 13);
			else if (off < 2368) put_bits({4'b1110, 11'(off - 320)}, 15);
			else put_bits({3'b110, 16'(off - 2368)}, 19);
		end else begin
			if (off < 64) put_bits({4'b1111, off[5:0]}, 10);
			else if (off < 320) put_bits({4'b1110, 8'(off - 64)}, 12);
			else put_bits({3'b110, 13'(off - 320)}, 16);
		end
		put_length(len);
	endfunction

	// Packs the bit stream into bytes; zero padding ends in a clean stall.
	function automatic void pack_bytes(ref logic [7:0] bytes[$]);
		logic [7:0] b;
		while (stream_bits.size() > 0) begin
			b = '0;
			for (int i = 7; i >= 0; i--)
				if (stream_bits.size() > 0) b[i] = stream_bits.pop_front();
			bytes.push_back(b);
		end
	endfunction

	// Sends one item in sender bursts and records what it should cause.
	task automatic send_item(in_item_t it);
		out_item_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = steady_sender ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.item <= it;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		if (decompress_step(it, r)) expected_results.push_back(r);
	endtask

	task automatic send_read(logic [15:0] addr);
		in_item_t it;
		it = in_item_t'($urandom());
		it.operation = OP_READ;
		it.read_address = addr;
		send_item(it);
	endtask

	// Sends a packet's bytes; flag bits on later items carry random noise.
	task automatic send_packet(logic [7:0] bytes[$], bit rst, bit mtf, bit comp, bit hist64,
			bit mark_first, bit mark_last);
		in_item_t it;
		int n;
		n = bytes.size();
		if (n == 0 && mark_last) begin
			it = in_item_t'($urandom());
			it.operation = OP_PACKET;
			it.byte_valid = 1'b0;
			it.first_of_packet = mark_first;
			it.last_of_packet = 1'b1;
			{it.reset_history, it.move_to_front, it.packet_compressed, it.large_history} =
				{rst, mtf, comp, hist64};
			send_item(it);
			return;
		end
		for (int i = 0; i < n; i++) begin
			it = in_item_t'({$urandom(), $urandom()});
			it.operation = OP_PACKET;
			it.byte_valid = 1'b1;
			it.data_byte = bytes[i];
			it.first_of_packet = (i == 0) && mark_first;
			it.last_of_packet = (i == n - 1) && mark_last;
			if (it.first_of_packet)
				{it.reset_history, it.move_to_front, it.packet_compressed,
					it.large_history} = {rst, mtf, comp, hist64};
			send_item(it);
			// A filler item with no byte is ignored apart from its flags.
			if (i < n - 1 && $urandom_range(0, 99) < 3) begin
				it.byte_valid = 1'b0;
				it.first_of_packet = 1'b0;
				it.last_of_packet = 1'b0;
				send_item(it);
			end
		end
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all of the history with a short pattern and one long copy.
	task automatic test_fill_history();
		logic [7:0] bytes[$];
		for (int i = 0; i < 64; i++) put_literal(8'($urandom()));
		put_copy(64, HISTORY_BYTES - 64, 1'b1);
		pack_bytes(bytes);
		send_packet(bytes, 1, 1, 1, 1, 1, 1);
		wait_drained();
	endtask

	// Field extremes, every token kind in 8K coding, every offset kind in 64K and each error.
	task automatic test_directed_tokens();
		logic [7:0] bytes[$];
		send_read(16'h0000);
		send_read(16'hFFFF);
		bytes = '{8'h00, 8'hFF};
		send_packet(bytes, 0, 0, 0, 0, 1, 1);
		bytes = {};
		send_packet(bytes, 0, 0, 0, 0, 1, 1);
		send_packet(bytes, 0, 1, 1, 1, 1, 1);
		// 8K coding with wrapped copy sources and a 4095-byte copy.
		put_literal(8'h00); put_literal(8'h7F); put_literal(8'h80); put_literal(8'hFF);
		put_copy(5000, 3, 0); put_copy(63, 4, 0); put_copy(64, 7, 0);
		put_copy(319, 8, 0); put_copy(320, 4095, 0); put_copy(8511, 3, 0);
		pack_bytes(bytes);
		send_packet(bytes, 1, 1, 1, 0, 1, 1);
		bytes = {};
		// 64K coding over all offset ranges.
		put_literal(8'h55); put_copy(1, 3, 1); put_copy(63, 5, 1); put_copy(64, 6, 1);
		put_copy(319, 3, 1); put_copy(320, 9, 1); put_copy(2367, 3, 1);
		put_copy(2368, 3, 1); put_copy(60000, 20, 1);
		pack_bytes(bytes);
		send_packet(bytes, 0, 1, 1, 1, 1, 1);
		bytes = {};
		// Offset beyond one wrap.
		put_literal(8'h11); put_copy(67903, 3, 1);
		pack_bytes(bytes);
		send_packet(bytes, 0, 1, 1, 1, 1, 1);
		bytes = {};
		// Short offset followed by a length run that is too long for 8K coding.
		put_bits(10'h3C1, 10);
		put_bits(13'h1FFE, 13);
		pack_bytes(bytes);
		send_packet(bytes, 0, 1, 1, 0, 1, 1);
		bytes = {};
		// Packet cut in the middle of an offset.
		put_bits(8'hFF, 8);
		pack_bytes(bytes);
		send_packet(bytes, 0, 0, 1, 1, 1, 1);
		wait_drained();
	endtask

	// Builds one random packet; most are well formed with random content.
	task automatic send_random_packet();
		logic [7:0] bytes[$];
		bit comp, hist64, rst, mtf, mark_first, mark_last;
		int n_tok, sel, max_off, max_len;
		int unsigned off, len;
		comp = $urandom_range(0, 99) < 80;
		hist64 = $urandom_range(0, 1);
		rst = $urandom_range(0, 99) < 10;
		mtf = $urandom_range(0, 99) < 40;
		mark_first = $urandom_range(0, 99) >= 5;
		mark_last = $urandom_range(0, 99) >= 4;
		if (!comp) begin
			repeat ($urandom_range(1, 8)) bytes.push_back(8'($urandom()));
		end else if ($urandom_range(0, 99) < 6) begin
			repeat ($urandom_range(1, 10)) bytes.push_back(8'($urandom()));
		end else begin
			n_tok = $urandom_range(1, 12);
			max_off = hist64 ? 2368 + 65535 : 320 + 8191;
			max_len = hist64 ? 65535 : 8191;
			repeat (n_tok) begin
				sel = $urandom_range(0, 99);
				if (sel < 45) begin
					put_literal(8'($urandom()));
				end else if (sel < 97) begin
					sel = $urandom_range(0, 99);
					if (sel < 40) off = $urandom_range(0, 63);
					else if (sel < 60) off = $urandom_range(64, 319);
					else if (sel < 80) off = $urandom_range(320, 2367);
					else off = $urandom_range(0, max_off);
					sel = $urandom_range(0, 99);
					if (sel < 60) len = $urandom_range(3, 10);
					else if (sel < 90) len = $urandom_range(3, 200);
					else if (sel < 99) len = $urandom_range(3, 1000);
					else len = $urandom_range(3, max_len);
					put_copy(off, len, hist64);
				end else begin
					put_copy($urandom_range(0, 63), 3, hist64);
					void'(stream_bits.pop_back());
					put_bits(16'hFFFF, $urandom_range(12, 16));
					put_bits(0, 1);
				end
			end
			pack_bytes(bytes);
			if (bytes.size() > 1 && $urandom_range(0, 99) < 8)
				bytes = bytes[0:bytes.size() - 2];
		end
		if ($urandom_range(0, 99) < 4) bytes = {};
		send_packet(bytes, rst, mtf, comp, hist64, mark_first, mark_last || bytes.size() == 0);
	endtask

	task automatic test_random_traffic();
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 15) send_read(16'($urandom()));
			else send_random_packet();
			if ($urandom_range(0, 99) < 5) steady_sender = ~steady_sender;
		end
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps offering, then a full pause.
	task automatic test_backpressure();
		logic [7:0] bytes[$];
		@(negedge clk);
		hold_request = 1'b1;
		@(posedge clk);
		steady_sender = 1'b1;
		for (int i = 0; i < 30; i++) send_read(16'($urandom()));
		bytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
		send_packet(bytes, 0, 0, 0, 0, 1, 1);
		steady_sender = 1'b0;
		wait_drained();
	endtask

	task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Result checking and the receiver's stall pattern.
	always @(posedge clk) begin
		int mode_left;
		int rx_mode;
		out_item_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer, kind %0d", out_ch.item.result_kind);
				mismatch_count++;
			end else begin
				exp_r = expected_results.pop_front();
				compare_field("result_kind", exp_r.result_kind, out_ch.item.result_kind);
				compare_field("status", exp_r.status, out_ch.item.status);
				compare_field("start_index", exp_r.start_index, out_ch.item.start_index);
				compare_field("packet_length", exp_r.packet_length,
					out_ch.item.packet_length);
				compare_field("out_byte", exp_r.out_byte, out_ch.item.out_byte);
				compare_field("out_last", exp_r.out_last, out_ch.item.out_last);
			end
		end
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 400;
		end
		if (mode_left == 0) begin
			mode_left = $urandom_range(64, 256);
			rx_mode = $urandom_range(0, 2);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (rx_mode == 0) begin
			out_ch.ready <= 1'b1;
		end else if (rx_mode == 1) begin
			out_ch.ready <= $urandom_range(0, 1);
		end else begin
			out_ch.ready <= $urandom_range(0, 4) == 0;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		int idle_cycles;
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.item = '0;
		out_ch.ready = 1'b0;
		mismatch_count = 0;
		items_sent = 0;
		burst_left = 0;
		steady_sender = 1'b0;
		hold_left = 0;
		hold_request = 1'b0;
		wr_idx = 0;
		pkt_start = 0;
		valid_size = 0;
		pkt_mode = 0;
		clear_decoder();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_history();
		test_directed_tokens();
		test_backpressure();
		test_random_traffic();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mppc_pkg.sv
sv/mppc_in_if.sv
sv/mppc_out_if.sv
sv/mppc_ram.sv
sv/mppc_history_decompressor_unit.sv
test/mppc_history_decompressor_unit_tb.sv
